@@ rtl/core/binomial_mod_prime_assert.svh @@
// Assertion helpers for the binomial coefficient block.
`ifndef BINOMIAL_MOD_PRIME_ASSERT_SVH
`define BINOMIAL_MOD_PRIME_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define BMP_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BMP_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/bmp_pkg.sv @@
`timescale 1ns / 1ps

package bmp_pkg;

  localparam int COEF_W             = 30;
  localparam int FIELD_W            = 16;
  localparam int DEFAULT_TABLE_SIZE = 4096;
  localparam int QUEUE_DEPTH        = 2;
  localparam int MUL_LATENCY        = 4;

  localparam logic [63:0]       PRIME_WIDE = 64'd1000000007;
  localparam logic [COEF_W-1:0] PRIME_MOD  = 30'd1000000007;
  localparam logic [31:0]       PRIME_32   = 32'd1000000007;
  localparam logic [31:0]       TWO_PRIME  = 32'd2000000014;

  // Barrett constant floor(2^60 / P), fits in 31 bits
  localparam logic [63:0] BARRETT_WIDE = (64'd1 << 60) / PRIME_WIDE;
  localparam logic [30:0] BARRETT_MU   = BARRETT_WIDE[30:0];

  // Fermat inverse exponent P - 2
  localparam int                EXP_BITS = 30;
  localparam logic [63:0]       EXP_WIDE = PRIME_WIDE - 64'd2;
  localparam logic [EXP_BITS-1:0] POW_EXP = EXP_WIDE[EXP_BITS-1:0];

  typedef enum logic [1:0] {
    CLS_NORMAL,
    CLS_ZERO,
    CLS_OOR
  } cls_t;

  typedef struct packed {
    logic [FIELD_W-1:0] n_value;
    logic [FIELD_W-1:0] r_value;
    cls_t               cls;
  } query_t;

  typedef struct packed {
    logic   valid;
    query_t q;
  } head_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FACT_INIT,
    ST_FACT_MUL,
    ST_FACT_WAIT,
    ST_POW_SQ,
    ST_POW_MUL,
    ST_POW_WAIT,
    ST_INV_INIT,
    ST_INV_MUL,
    ST_INV_WAIT,
    ST_Q_RD1,
    ST_Q_RD2,
    ST_Q_CAP,
    ST_Q_WAIT1,
    ST_Q_WAIT2
  } state_t;

endpackage

@@ rtl/core/bmp_ram.sv @@
`timescale 1ns / 1ps

module bmp_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 4097,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/bmp_mulmod.sv @@
`timescale 1ns / 1ps

// a*b mod P, four stages: product, Barrett quotient estimate,
// quotient times P, remainder with up to two corrections.
module bmp_mulmod import bmp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [COEF_W-1:0] a,
  input  logic [COEF_W-1:0] b,
  output logic              out_valid,
  output logic [COEF_W-1:0] result
);

  logic [59:0] prod;
  logic [59:0] x1;
  logic [61:0] q2;
  logic [31:0] x2;
  logic [60:0] qp_full;
  logic [31:0] qp3;
  logic [31:0] x3;
  logic [31:0] rem;
  logic [31:0] rem_fix;
  logic [MUL_LATENCY-1:0] vld;

  assign prod    = 60'(a) * 60'(b);
  assign qp_full = 61'(q2[61:31]) * 61'(PRIME_MOD);
  assign rem     = x3 - qp3;

  // rem < 3P here
  always_comb begin
    priority if (rem >= TWO_PRIME) begin
      rem_fix = rem - TWO_PRIME;
    end else if (rem >= PRIME_32) begin
      rem_fix = rem - PRIME_32;
    end else begin
      rem_fix = rem;
    end
  end

  always_ff @(posedge clk) begin
    x1     <= prod;
    q2     <= 62'(x1[59:29]) * 62'(BARRETT_MU);
    x2     <= x1[31:0];
    qp3    <= qp_full[31:0];
    x3     <= x2;
    result <= rem_fix[COEF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[MUL_LATENCY-2:0], in_valid};
    end
  end

  assign out_valid = vld[MUL_LATENCY-1];

endmodule

@@ rtl/core/bmp_front.sv @@
`timescale 1ns / 1ps

// Takes queries, tags them, holds them in a short queue.
module bmp_front import bmp_pkg::*; #(
  parameter int TABLE_SIZE = DEFAULT_TABLE_SIZE
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [FIELD_W-1:0] n_value,
  input  logic [FIELD_W-1:0] r_value,
  output head_t              head,
  input  logic               pop
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [31:0] TOP = 32'(TABLE_SIZE);

  query_t        slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          take;
  query_t        incoming;

  assign busy = (count == CW'(QUEUE_DEPTH));
  assign push = start && !busy;
  assign take = pop && (count != '0);

  always_comb begin
    incoming.n_value = n_value;
    incoming.r_value = r_value;
    priority if (32'(n_value) > TOP) begin
      incoming.cls = CLS_OOR;
    end else if (r_value > n_value) begin
      incoming.cls = CLS_ZERO;
    end else begin
      incoming.cls = CLS_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (take) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({push, take})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  assign head.valid = (count != '0);
  assign head.q     = slots[rd_ptr];

endmodule

@@ rtl/core/bmp_back.sv @@
`timescale 1ns / 1ps

// Builds the tables once, then serves queries from the queue head.
module bmp_back import bmp_pkg::*; #(
  parameter int TABLE_SIZE = DEFAULT_TABLE_SIZE,
  localparam int AW        = $clog2(TABLE_SIZE + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  head_t             head,
  output logic              pop,
  output logic              mul_in_valid,
  output logic [COEF_W-1:0] mul_a,
  output logic [COEF_W-1:0] mul_b,
  input  logic              mul_out_valid,
  input  logic [COEF_W-1:0] mul_result,
  output logic              fact_we,
  output logic [AW-1:0]     fact_waddr,
  output logic [COEF_W-1:0] fact_wdata,
  output logic [AW-1:0]     fact_raddr,
  input  logic [COEF_W-1:0] fact_rdata,
  output logic              inv_we,
  output logic [AW-1:0]     inv_waddr,
  output logic [COEF_W-1:0] inv_wdata,
  output logic [AW-1:0]     inv_raddr,
  input  logic [COEF_W-1:0] inv_rdata,
  output logic              done,
  output logic [COEF_W-1:0] coefficient,
  output logic              out_of_range
);

  localparam int BW = $clog2(EXP_BITS);
  localparam logic [AW-1:0] K_TOP    = AW'(TABLE_SIZE);
  localparam logic [BW-1:0] POW_LAST = BW'(EXP_BITS - 1);
  localparam logic [COEF_W-1:0] ONE  = COEF_W'(1);

  state_t            state, state_next;
  logic [AW-1:0]     k, k_next;
  logic [COEF_W-1:0] run, run_next;
  logic [COEF_W-1:0] sq, sq_next;
  logic [COEF_W-1:0] term, term_next;
  logic [BW-1:0]     bit_idx, bit_idx_next;
  logic              got_first, got_first_next;
  logic              built, built_next;
  logic              done_next;
  logic [COEF_W-1:0] coefficient_next;
  logic              out_of_range_next;

  logic [31:0]        n_wide;
  logic [31:0]        r_wide;
  logic [31:0]        d_wide;
  logic [FIELD_W-1:0] diff;

  assign diff   = head.q.n_value - head.q.r_value;
  assign n_wide = 32'(head.q.n_value);
  assign r_wide = 32'(head.q.r_value);
  assign d_wide = 32'(diff);

  assign fact_raddr = n_wide[AW-1:0];
  assign inv_raddr  = (state == ST_Q_RD2) ? d_wide[AW-1:0] : r_wide[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      built     <= 1'b0;
      got_first <= 1'b0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      built     <= built_next;
      got_first <= got_first_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    k            <= k_next;
    run          <= run_next;
    sq           <= sq_next;
    term         <= term_next;
    bit_idx      <= bit_idx_next;
    coefficient  <= coefficient_next;
    out_of_range <= out_of_range_next;
  end

  always_comb begin
    state_next        = state;
    k_next            = k;
    run_next          = run;
    sq_next           = sq;
    term_next         = term;
    bit_idx_next      = bit_idx;
    got_first_next    = got_first;
    built_next        = built;
    done_next         = 1'b0;
    coefficient_next  = coefficient;
    out_of_range_next = out_of_range;
    pop               = 1'b0;
    mul_in_valid      = 1'b0;
    mul_a             = run;
    mul_b             = COEF_W'(k);
    fact_we           = 1'b0;
    fact_waddr        = k;
    fact_wdata        = mul_result;
    inv_we            = 1'b0;
    inv_waddr         = k - AW'(1);
    inv_wdata         = mul_result;

    unique case (state)
      ST_IDLE: begin
        if (head.valid) begin
          if (!built) begin
            state_next = ST_FACT_INIT;
          end else begin
            unique case (head.q.cls)
              CLS_OOR: begin
                done_next         = 1'b1;
                coefficient_next  = '0;
                out_of_range_next = 1'b1;
                pop               = 1'b1;
              end
              CLS_ZERO: begin
                done_next         = 1'b1;
                coefficient_next  = '0;
                out_of_range_next = 1'b0;
                pop               = 1'b1;
              end
              CLS_NORMAL: begin
                state_next = ST_Q_RD1;
              end
              default: begin
                state_next = ST_IDLE;
              end
            endcase
          end
        end
      end
      ST_FACT_INIT: begin
        fact_we    = 1'b1;
        fact_waddr = '0;
        fact_wdata = ONE;
        run_next   = ONE;
        k_next     = AW'(1);
        state_next = ST_FACT_MUL;
      end
      ST_FACT_MUL: begin
        mul_in_valid = 1'b1;
        state_next   = ST_FACT_WAIT;
      end
      ST_FACT_WAIT: begin
        if (mul_out_valid) begin
          fact_we  = 1'b1;
          run_next = mul_result;
          if (k == K_TOP) begin
            // top factorial becomes the base, accumulator restarts at one
            sq_next        = mul_result;
            run_next       = ONE;
            bit_idx_next   = '0;
            got_first_next = 1'b0;
            state_next     = ST_POW_SQ;
          end else begin
            k_next     = k + AW'(1);
            state_next = ST_FACT_MUL;
          end
        end
      end
      ST_POW_SQ: begin
        mul_in_valid = 1'b1;
        mul_a        = sq;
        mul_b        = sq;
        state_next   = ST_POW_MUL;
      end
      ST_POW_MUL: begin
        mul_in_valid = 1'b1;
        mul_a        = run;
        mul_b        = sq;
        state_next   = ST_POW_WAIT;
      end
      ST_POW_WAIT: begin
        if (mul_out_valid) begin
          if (!got_first) begin
            sq_next        = mul_result;
            got_first_next = 1'b1;
          end else begin
            got_first_next = 1'b0;
            if (POW_EXP[bit_idx]) begin
              run_next = mul_result;
            end
            if (bit_idx == POW_LAST) begin
              state_next = ST_INV_INIT;
            end else begin
              bit_idx_next = bit_idx + BW'(1);
              state_next   = ST_POW_SQ;
            end
          end
        end
      end
      ST_INV_INIT: begin
        inv_we     = 1'b1;
        inv_waddr  = K_TOP;
        inv_wdata  = run;
        k_next     = K_TOP;
        state_next = ST_INV_MUL;
      end
      ST_INV_MUL: begin
        mul_in_valid = 1'b1;
        state_next   = ST_INV_WAIT;
      end
      ST_INV_WAIT: begin
        if (mul_out_valid) begin
          inv_we   = 1'b1;
          run_next = mul_result;
          if (k == AW'(1)) begin
            built_next = 1'b1;
            state_next = ST_IDLE;
          end else begin
            k_next     = k - AW'(1);
            state_next = ST_INV_MUL;
          end
        end
      end
      ST_Q_RD1: begin
        state_next = ST_Q_RD2;
      end
      ST_Q_RD2: begin
        // fact[n] and inv[r] are out; inv[n-r] is being read
        mul_in_valid = 1'b1;
        mul_a        = fact_rdata;
        mul_b        = inv_rdata;
        state_next   = ST_Q_CAP;
      end
      ST_Q_CAP: begin
        term_next  = inv_rdata;
        state_next = ST_Q_WAIT1;
      end
      ST_Q_WAIT1: begin
        if (mul_out_valid) begin
          mul_in_valid = 1'b1;
          mul_a        = mul_result;
          mul_b        = term;
          state_next   = ST_Q_WAIT2;
        end
      end
      ST_Q_WAIT2: begin
        if (mul_out_valid) begin
          done_next         = 1'b1;
          coefficient_next  = mul_result;
          out_of_range_next = 1'b0;
          pop               = 1'b1;
          state_next        = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/binomial_mod_prime.sv @@
// A query with r > n or n > TABLE_SIZE is answered from the idle state; an
//   in-range query with r <= n reads both tables, then makes two dependent passes
//   through the four-stage mod multiplier. The first query after reset adds a table
//   build (one mod-multiply round trip per entry, twice). Queries go in order, one at
//   a time; once built, zero-result queries retire one per cycle when none is in flight.
// Reset: synchronous rst clears control; tables are rebuilt on the next query.
`timescale 1ns / 1ps
`include "binomial_mod_prime_assert.svh"

module binomial_mod_prime import bmp_pkg::*; #(
  parameter int TABLE_SIZE = DEFAULT_TABLE_SIZE
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [FIELD_W-1:0] n_value,
  input  logic [FIELD_W-1:0] r_value,
  output logic               done,
  output logic [COEF_W-1:0]  coefficient,
  output logic               out_of_range
);

  localparam int DEPTH = TABLE_SIZE + 1;
  localparam int AW    = $clog2(DEPTH);

  // Queue head from front to back, and the pop that retires it
  head_t head;
  logic  pop;

  // Shared mod multiplier
  logic              mul_in_valid;
  logic [COEF_W-1:0] mul_a;
  logic [COEF_W-1:0] mul_b;
  logic              mul_out_valid;
  logic [COEF_W-1:0] mul_result;

  // Table ports
  logic              fact_we;
  logic [AW-1:0]     fact_waddr;
  logic [COEF_W-1:0] fact_wdata;
  logic [AW-1:0]     fact_raddr;
  logic [COEF_W-1:0] fact_rdata;
  logic              inv_we;
  logic [AW-1:0]     inv_waddr;
  logic [COEF_W-1:0] inv_wdata;
  logic [AW-1:0]     inv_raddr;
  logic [COEF_W-1:0] inv_rdata;

  // Front: a transaction is taken when start is high and busy low; it is
  // classified (out of range, r above n, normal) and queued.
  bmp_front #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .n_value (n_value),
    .r_value (r_value),
    .head    (head),
    .pop     (pop)
  );

  // Back: one-time table build, then fact[n] * inv[r] * inv[n-r]
  bmp_back #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .mul_in_valid  (mul_in_valid),
    .mul_a         (mul_a),
    .mul_b         (mul_b),
    .mul_out_valid (mul_out_valid),
    .mul_result    (mul_result),
    .fact_we       (fact_we),
    .fact_waddr    (fact_waddr),
    .fact_wdata    (fact_wdata),
    .fact_raddr    (fact_raddr),
    .fact_rdata    (fact_rdata),
    .inv_we        (inv_we),
    .inv_waddr     (inv_waddr),
    .inv_wdata     (inv_wdata),
    .inv_raddr     (inv_raddr),
    .inv_rdata     (inv_rdata),
    .done          (done),
    .coefficient   (coefficient),
    .out_of_range  (out_of_range)
  );

  // Barrett-reduced multiplier, pipelined four deep
  bmp_mulmod u_mulmod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_in_valid),
    .a         (mul_a),
    .b         (mul_b),
    .out_valid (mul_out_valid),
    .result    (mul_result)
  );

  // Factorial table
  bmp_ram #(
    .WIDTH (COEF_W),
    .DEPTH (DEPTH)
  ) u_fact_ram (
    .clk   (clk),
    .we    (fact_we),
    .waddr (fact_waddr),
    .wdata (fact_wdata),
    .raddr (fact_raddr),
    .rdata (fact_rdata)
  );

  // Inverse factorial table
  bmp_ram #(
    .WIDTH (COEF_W),
    .DEPTH (DEPTH)
  ) u_inv_ram (
    .clk   (clk),
    .we    (inv_we),
    .waddr (inv_waddr),
    .wdata (inv_wdata),
    .raddr (inv_raddr),
    .rdata (inv_rdata)
  );

  // An out-of-range result always carries a zero coefficient
  `BMP_ASSERT_NOW(a_oor_zero, clk, rst, done && out_of_range, coefficient == '0, "oor result not zero")
  // Every result is fully reduced
  `BMP_ASSERT_NOW(a_reduced, clk, rst, done, coefficient < PRIME_MOD, "result not reduced mod P")
  // Retiring a queue entry produces exactly the result of the next cycle
  `BMP_ASSERT_NEXT(a_pop_done, clk, rst, pop, done, "pop without result")
  // Multiplier output only appears for an earlier issue that has run through the whole pipeline
  `BMP_ASSERT_NOW(a_mul_lat, clk, rst, mul_out_valid, $past(mul_in_valid, MUL_LATENCY), "stray product")

endmodule
